// ===== rtl/i2cdac_pkg.sv =====
// shared types and constants for the i2c dac register model
// event kinds, write modes, queued beat and result layouts
// no dependencies
`default_nettype none

package i2cdac_pkg;

  localparam int unsigned CODE_W = 12;
  localparam int unsigned BUSY_W = 16;
  localparam int unsigned PD_W   = 2;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CODE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_PD      = 2'd2;

  localparam logic [BUSY_W-1:0] BUSY_TICKS_RST = 16'd50;
  localparam logic [CODE_W-1:0] INIT_CODE_RST  = 12'd2048;
  localparam logic [PD_W-1:0]   INIT_PD_RST    = 2'd0;

  localparam logic [POS_W-1:0] POS_LAST = 3'd4;
  localparam logic [POS_W-1:0] POS_WRAP = 3'd5;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_TICK  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CMD_FAST,
    CMD_PERSIST,
    CMD_OTHER
  } cmd_e;

  typedef struct packed {
    kind_e      kind;
    cmd_e       cmd;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]        read_byte;
    logic [CODE_W-1:0] dac_code;
    logic [PD_W-1:0]   power_down_mode;
    logic              eeprom_busy;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/i2cdac_front.sv =====
// front end: takes bus event beats, classifies command bytes
// and holds them in a two-entry queue for the back end; uses i2cdac_pkg
`default_nettype none

module i2cdac_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic [7:0]         byte_in_i,
  output logic                    valid_o,
  output i2cdac_pkg::item_t       item_o,
  input  wire logic               pop_i
);

  logic [1:0]        cnt_q, cnt_d;
  logic              wp_q, rp_q;
  logic              push_ok, pop_ok;
  i2cdac_pkg::item_t item;
  i2cdac_pkg::item_t mem_q [2];

  // command class from the top bits of the byte
  always_comb begin
    item.kind = i2cdac_pkg::kind_e'(kind_i);
    item.data = byte_in_i;
    if (byte_in_i[7:6] == 2'b00) begin
      item.cmd = i2cdac_pkg::CMD_FAST;
    end else if (byte_in_i[7:5] == 3'b011) begin
      item.cmd = i2cdac_pkg::CMD_PERSIST;
    end else begin
      item.cmd = i2cdac_pkg::CMD_OTHER;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rp_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && valid_o;
  assign cnt_d   = cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_ok) begin
        wp_q <= !wp_q;
      end
      if (pop_ok) begin
        rp_q <= !rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wp_q] <= item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2cdac_back.sv =====
// back end: transaction state, output and stored dac values, eeprom busy
// counter and configuration registers; one beat executed per cycle unless the result queue is full; uses i2cdac_pkg
`default_nettype none

module i2cdac_back (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [i2cdac_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [i2cdac_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                                 valid_i,
  input  wire i2cdac_pkg::item_t                    item_i,
  output logic                                      pop_o,
  input  wire logic                                 res_full_i,
  output logic                                      res_push_o,
  output i2cdac_pkg::result_t                       res_o
);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_FAST    = 2'd1,
    MODE_PERSIST = 2'd2,
    MODE_DISCARD = 2'd3
  } mode_e;

  mode_e                               mode_q, mode_d;
  logic [i2cdac_pkg::POS_W-1:0]        pos_q, pos_d, rd_pos;
  logic [i2cdac_pkg::CODE_W-1:0]       pend_code_q, pend_code_d;
  logic [i2cdac_pkg::PD_W-1:0]         pend_pd_q, pend_pd_d;
  logic [i2cdac_pkg::CODE_W-1:0]       out_code_q, out_code_d;
  logic [i2cdac_pkg::PD_W-1:0]         out_pd_q, out_pd_d;
  logic [i2cdac_pkg::CODE_W-1:0]       st_code_q, st_code_d;
  logic [i2cdac_pkg::PD_W-1:0]         st_pd_q, st_pd_d;
  logic [i2cdac_pkg::BUSY_W-1:0]       busy_q, busy_d;
  logic [i2cdac_pkg::BUSY_W-1:0]       ticks_q, ticks_d;
  logic [7:0]                          rd_byte;
  logic                                exec;

  assign exec  = valid_i && !res_full_i;
  assign pop_o = exec;

  always_comb begin
    mode_d      = mode_q;
    pos_d       = pos_q;
    pend_code_d = pend_code_q;
    pend_pd_d   = pend_pd_q;
    out_code_d  = out_code_q;
    out_pd_d    = out_pd_q;
    st_code_d   = st_code_q;
    st_pd_d     = st_pd_q;
    busy_d      = busy_q;
    ticks_d     = ticks_q;
    rd_byte     = 8'h00;
    rd_pos      = (mode_q != MODE_IDLE) ? '0 : pos_q;
    if (rd_pos > i2cdac_pkg::POS_LAST) begin
      rd_pos = '0;
    end

    if (exec) begin
      case (item_i.kind)
        i2cdac_pkg::KIND_WRITE: begin
          case (mode_q)
            MODE_IDLE: begin
              if (pos_q != '0 || busy_q != '0) begin
                mode_d = MODE_DISCARD;
              end else if (item_i.cmd == i2cdac_pkg::CMD_FAST) begin
                mode_d      = MODE_FAST;
                pend_pd_d   = item_i.data[5:4];
                pend_code_d = {item_i.data[3:0], 8'h00};
                pos_d       = 3'd1;
              end else if (item_i.cmd == i2cdac_pkg::CMD_PERSIST) begin
                mode_d      = MODE_PERSIST;
                pend_pd_d   = item_i.data[2:1];
                pend_code_d = '0;
                pos_d       = 3'd1;
              end else begin
                mode_d = MODE_DISCARD;
              end
            end
            MODE_FAST: begin
              if (pos_q == 3'd1) begin
                pend_code_d = {pend_code_q[11:8], item_i.data};
                out_code_d  = {pend_code_q[11:8], item_i.data};
                out_pd_d    = pend_pd_q;
                pos_d       = 3'd2;
              end
            end
            MODE_PERSIST: begin
              if (pos_q == 3'd1) begin
                pend_code_d = {item_i.data, 4'h0};
                pos_d       = 3'd2;
              end else if (pos_q == 3'd2) begin
                pend_code_d = {pend_code_q[11:4], item_i.data[7:4]};
                out_code_d  = {pend_code_q[11:4], item_i.data[7:4]};
                st_code_d   = {pend_code_q[11:4], item_i.data[7:4]};
                out_pd_d    = pend_pd_q;
                st_pd_d     = pend_pd_q;
                busy_d      = ticks_q;
                pos_d       = 3'd3;
              end
            end
            default: begin
            end
          endcase
        end
        i2cdac_pkg::KIND_READ: begin
          mode_d = MODE_IDLE;
          unique case (rd_pos)
            3'd0:    rd_byte = {(busy_q == '0), 4'b0000, out_pd_q, 1'b0};
            3'd1:    rd_byte = out_code_q[11:4];
            3'd2:    rd_byte = {out_code_q[3:0], 4'h0};
            3'd3:    rd_byte = {1'b0, st_pd_q, 1'b0, st_code_q[11:8]};
            default: rd_byte = st_code_q[7:0];
          endcase
          pos_d = (rd_pos >= i2cdac_pkg::POS_LAST) ? i2cdac_pkg::POS_WRAP : rd_pos + 3'd1;
        end
        i2cdac_pkg::KIND_STOP: begin
          mode_d      = MODE_IDLE;
          pos_d       = '0;
          pend_code_d = '0;
          pend_pd_d   = '0;
        end
        default: begin
          if (busy_q != '0) begin
            busy_d = busy_q - 16'd1;
          end
        end
      endcase
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        i2cdac_pkg::CFG_BUSY_TICKS: ticks_d = cfg_wdata_i;
        i2cdac_pkg::CFG_INIT_CODE: begin
          out_code_d = cfg_wdata_i[i2cdac_pkg::CODE_W-1:0];
          st_code_d  = cfg_wdata_i[i2cdac_pkg::CODE_W-1:0];
        end
        i2cdac_pkg::CFG_INIT_PD: begin
          out_pd_d = cfg_wdata_i[i2cdac_pkg::PD_W-1:0];
          st_pd_d  = cfg_wdata_i[i2cdac_pkg::PD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign res_push_o            = exec;
  assign res_o.read_byte       = rd_byte;
  assign res_o.dac_code        = out_code_d;
  assign res_o.power_down_mode = out_pd_d;
  assign res_o.eeprom_busy     = (busy_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      pos_q       <= '0;
      pend_code_q <= '0;
      pend_pd_q   <= '0;
      out_code_q  <= i2cdac_pkg::INIT_CODE_RST;
      out_pd_q    <= i2cdac_pkg::INIT_PD_RST;
      st_code_q   <= i2cdac_pkg::INIT_CODE_RST;
      st_pd_q     <= i2cdac_pkg::INIT_PD_RST;
      busy_q      <= '0;
      ticks_q     <= i2cdac_pkg::BUSY_TICKS_RST;
    end else begin
      mode_q      <= mode_d;
      pos_q       <= pos_d;
      pend_code_q <= pend_code_d;
      pend_pd_q   <= pend_pd_d;
      out_code_q  <= out_code_d;
      out_pd_q    <= out_pd_d;
      st_code_q   <= st_code_d;
      st_pd_q     <= st_pd_d;
      busy_q      <= busy_d;
      ticks_q     <= ticks_d;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= i2cdac_pkg::POS_WRAP)
    else $error("byte position out of range");

  a_fast_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_FAST) |-> (pos_q == 3'd1 || pos_q == 3'd2))
    else $error("fast write at bad position");

  a_persist_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_PERSIST) |-> (pos_q == 3'd1 || pos_q == 3'd2 || pos_q == 3'd3))
    else $error("persistent write at bad position");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && item_i.kind == i2cdac_pkg::KIND_STOP && !cfg_we_i)
    |=> (mode_q == MODE_IDLE && pos_q == '0 && pend_code_q == '0))
    else $error("stop did not end the transaction");

  a_no_pop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_full_i |-> !pop_o)
    else $error("beat taken while result queue full");
`endif

endmodule

`default_nettype wire

// ===== rtl/i2cdac_outq.sv =====
// result queue: two-entry buffer between the back end and the result port
// uses i2cdac_pkg
`default_nettype none

module i2cdac_outq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire i2cdac_pkg::result_t  res_i,
  output logic                      full_o,
  output logic                      empty_o,
  input  wire logic                 pop_i,
  output i2cdac_pkg::result_t       res_o
);

  logic [1:0]          cnt_q, cnt_d;
  logic                wp_q, rp_q;
  logic                push_ok, pop_ok;
  i2cdac_pkg::result_t mem_q [2];

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign res_o   = mem_q[rp_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign cnt_d   = cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_ok) begin
        wp_q <= !wp_q;
      end
      if (pop_ok) begin
        rp_q <= !rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wp_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2c_dac_register_model.sv =====
// Device-side model of a 12-bit i2c dac with an eeprom copy. Each beat on the
// input queue is one bus event (write byte, read byte, stop, tick) and yields
// exactly one result beat: the read byte, the dac code, the power-down mode and
// the eeprom busy flag. One event is taken every cycle while the event queue is
// not full; each accepted event waits in the two-entry event queue, is executed
// combinationally once the two-entry result queue has room, and is registered
// into that result queue. Configuration writes are registered in the back end
// and also reach the dac code and power-down mode of a beat executed in the same cycle.
// Depends on i2cdac_pkg, i2cdac_front, i2cdac_back and i2cdac_outq.
`default_nettype none

module i2c_dac_register_model (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic [1:0]                           kind_i,
  input  wire logic [7:0]                           byte_in_i,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic [7:0]                                read_byte_o,
  output logic [i2cdac_pkg::CODE_W-1:0]             dac_code_o,
  output logic [i2cdac_pkg::PD_W-1:0]               power_down_mode_o,
  output logic                                      eeprom_busy_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [i2cdac_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [i2cdac_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  logic                q_valid, q_pop;
  logic                res_push, res_full;
  i2cdac_pkg::item_t   q_item;
  i2cdac_pkg::result_t res_in, res_out;

  i2cdac_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .kind_i    (kind_i),
    .byte_in_i (byte_in_i),
    .valid_o   (q_valid),
    .item_o    (q_item),
    .pop_i     (q_pop)
  );

  i2cdac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (q_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  i2cdac_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res_out)
  );

  assign read_byte_o       = res_out.read_byte;
  assign dac_code_o        = res_out.dac_code;
  assign power_down_mode_o = res_out.power_down_mode;
  assign eeprom_busy_o     = res_out.eeprom_busy;

endmodule

`default_nettype wire

// ===== sim/i2c_dac_register_model_tb.sv =====
// self-checking bench for i2c_dac_register_model: bus events go in through a driver fed
// from a queue of pending beats; a monitor compares each result beat with the prediction
// depends on i2cdac_pkg and the dac register model rtl
module i2c_dac_register_model_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cdac_pkg::*;

  typedef enum logic [1:0] {
    WM_IDLE,
    WM_FAST,
    WM_PERSIST,
    WM_DISCARD
  } wr_mode_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } bus_event_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_AT_BEAT   = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int QUIET_LO       = 600;
  localparam int QUIET_HI       = 800;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  push        = 1'b0;
  logic                  full;
  logic [1:0]            kind_i      = KIND_STOP;
  logic [7:0]            byte_in_i   = 8'h00;
  logic                  empty;
  logic                  pop         = 1'b0;
  logic [7:0]            read_byte_o;
  logic [CODE_W-1:0]     dac_code_o;
  logic [PD_W-1:0]       power_down_mode_o;
  logic                  eeprom_busy_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_BUSY_TICKS;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  i2c_dac_register_model u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .kind_i            (kind_i),
    .byte_in_i         (byte_in_i),
    .empty             (empty),
    .pop               (pop),
    .read_byte_o       (read_byte_o),
    .dac_code_o        (dac_code_o),
    .power_down_mode_o (power_down_mode_o),
    .eeprom_busy_o     (eeprom_busy_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // device state as the bus sees it
  logic [BUSY_W-1:0] busy_ticks;
  logic [CODE_W-1:0] init_code;
  logic [PD_W-1:0]   init_pd;
  logic [POS_W-1:0]  byte_pos;
  wr_mode_e          wr_mode;
  logic [CODE_W-1:0] pend_code;
  logic [PD_W-1:0]   pend_pd;
  logic [CODE_W-1:0] out_code;
  logic [PD_W-1:0]   out_pd;
  logic [CODE_W-1:0] nv_code;
  logic [PD_W-1:0]   nv_pd;
  logic [BUSY_W-1:0] busy_left;

  bus_event_t pending_events[$];
  result_t    dac_expect[$];
  int         n_in;
  int         n_out;
  int         errors;
  int         hold_left;
  int         stall_cycles;

  function automatic result_t predict_dac(input kind_e k, input logic [7:0] b);
    result_t    r;
    logic [7:0] rd;
    rd = 8'h00;
    case (k)
      KIND_WRITE: begin
        if (wr_mode == WM_IDLE) begin
          if (byte_pos != 0 || busy_left != 0) begin
            wr_mode = WM_DISCARD;
          end else if (b[7:6] == 2'b00) begin
            wr_mode   = WM_FAST;
            pend_pd   = b[5:4];
            pend_code = {b[3:0], 8'h00};
            byte_pos  = 3'd1;
          end else if (b[7:5] == 3'b011) begin
            wr_mode   = WM_PERSIST;
            pend_pd   = b[2:1];
            pend_code = '0;
            byte_pos  = 3'd1;
          end else begin
            wr_mode = WM_DISCARD;
          end
        end else if (wr_mode == WM_FAST) begin
          if (byte_pos == 3'd1) begin
            pend_code = {pend_code[11:8], b};
            out_code  = pend_code;
            out_pd    = pend_pd;
            byte_pos  = 3'd2;
          end
        end else if (wr_mode == WM_PERSIST) begin
          if (byte_pos == 3'd1) begin
            pend_code = {b, 4'h0};
            byte_pos  = 3'd2;
          end else if (byte_pos == 3'd2) begin
            pend_code = {pend_code[11:4], b[7:4]};
            out_code  = pend_code;
            out_pd    = pend_pd;
            nv_code   = pend_code;
            nv_pd     = pend_pd;
            busy_left = busy_ticks;
            byte_pos  = 3'd3;
          end
        end
      end
      KIND_READ: begin
        if (wr_mode != WM_IDLE) begin
          wr_mode  = WM_IDLE;
          byte_pos = '0;
        end
        if (byte_pos > POS_LAST) byte_pos = '0;
        case (byte_pos)
          3'd0:    rd = {(busy_left == 0), 4'b0000, out_pd, 1'b0};
          3'd1:    rd = out_code[11:4];
          3'd2:    rd = {out_code[3:0], 4'h0};
          3'd3:    rd = {1'b0, nv_pd, 1'b0, nv_code[11:8]};
          default: rd = nv_code[7:0];
        endcase
        // wrapped readback keeps a nonzero position so later writes are refused
        if (byte_pos >= POS_LAST) byte_pos = POS_WRAP;
        else byte_pos = byte_pos + 3'd1;
      end
      KIND_STOP: begin
        wr_mode   = WM_IDLE;
        byte_pos  = '0;
        pend_code = '0;
        pend_pd   = '0;
      end
      default: begin
        if (busy_left != 0) busy_left = busy_left - 1'b1;
      end
    endcase
    r.read_byte       = rd;
    r.dac_code        = out_code;
    r.power_down_mode = out_pd;
    r.eeprom_busy     = (busy_left != 0);
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    bus_event_t ev;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        ev = pending_events.pop_front();
        dac_expect.push_back(predict_dac(ev.kind, ev.data));
        n_in++;
      end
      if (pending_events.size() != 0 &&
          ((n_in >= QUIET_LO && n_in < QUIET_HI) || $urandom_range(0, 99) >= 25)) begin
        push      <= 1'b1;
        kind_i    <= pending_events[0].kind;
        byte_in_i <= pending_events[0].data;
      end else begin
        push <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (dac_expect.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %0h %0h %0h %0h", $time,
                   read_byte_o, dac_code_o, power_down_mode_o, eeprom_busy_o);
          errors++;
        end else begin
          want = dac_expect.pop_front();
          check_field("read_byte", want.read_byte, read_byte_o);
          check_field("dac_code", want.dac_code, dac_code_o);
          check_field("power_down_mode", want.power_down_mode, power_down_mode_o);
          check_field("eeprom_busy", want.eeprom_busy, eeprom_busy_o);
        end
        n_out++;
        // long receiver hold-off so the block fills and pushes back
        if (n_out == HOLD_AT_BEAT) hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= (n_out >= QUIET_LO && n_out < QUIET_HI) || $urandom_range(0, 99) >= 25;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("i2c_dac_register_model_tb: errors");
        $finish;
      end
    end
  end

  task automatic add_event(input kind_e k, input logic [7:0] b);
    bus_event_t ev;
    ev.kind = k;
    ev.data = b;
    pending_events.push_back(ev);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_BUSY_TICKS: busy_ticks = data;
      CFG_INIT_CODE: begin
        init_code = data[CODE_W-1:0];
        out_code  = init_code;
        nv_code   = init_code;
      end
      CFG_INIT_PD: begin
        init_pd = data[PD_W-1:0];
        out_pd  = init_pd;
        nv_pd   = init_pd;
      end
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || dac_expect.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_transaction();
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      add_event(KIND_WRITE, {2'b00, 6'($urandom)});
      add_event(KIND_WRITE, 8'($urandom));
      if ($urandom_range(0, 99) < 20) begin
        n = $urandom_range(1, 2);
        repeat (n) add_event(KIND_WRITE, 8'($urandom));
      end
      add_event(KIND_STOP, 8'($urandom));
    end else if (sel < 50) begin
      add_event(KIND_WRITE, {3'b011, 5'($urandom)});
      add_event(KIND_WRITE, 8'($urandom));
      add_event(KIND_WRITE, 8'($urandom));
      if ($urandom_range(0, 99) < 15) add_event(KIND_WRITE, 8'($urandom));
      add_event(KIND_STOP, 8'($urandom));
    end else if (sel < 65) begin
      n = $urandom_range(1, 7);
      repeat (n) add_event(KIND_READ, 8'($urandom));
      if ($urandom_range(0, 99) < 80) add_event(KIND_STOP, 8'($urandom));
    end else if (sel < 80) begin
      n = $urandom_range(1, 12);
      repeat (n) add_event(KIND_TICK, 8'($urandom));
    end else if (sel < 90) begin
      case ($urandom_range(0, 3))
        0: add_event(KIND_WRITE, {2'b00, 6'($urandom)});
        1: begin
          add_event(KIND_WRITE, {3'b011, 5'($urandom)});
          add_event(KIND_WRITE, 8'($urandom));
          add_event(KIND_READ, 8'($urandom));
        end
        2: begin
          if ($urandom_range(0, 1) != 0) add_event(KIND_WRITE, {3'b010, 5'($urandom)});
          else add_event(KIND_WRITE, {1'b1, 7'($urandom)});
          n = $urandom_range(1, 2);
          repeat (n) add_event(KIND_WRITE, 8'($urandom));
        end
        default: begin
          add_event(KIND_READ, 8'($urandom));
          add_event(KIND_WRITE, 8'($urandom));
        end
      endcase
      add_event(KIND_STOP, 8'($urandom));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) add_event(kind_e'($urandom_range(0, 3)), 8'($urandom));
    end
  endtask

  task automatic run_phase(input logic [15:0] ticks, input logic [15:0] code,
                           input logic [15:0] pd, input int n_items);
    write_reg(CFG_BUSY_TICKS, ticks);
    write_reg(CFG_INIT_CODE, code);
    write_reg(CFG_INIT_PD, pd);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    while (pending_events.size() < n_items) add_transaction();
    wait_drained();
  endtask

  initial begin
    busy_ticks = BUSY_TICKS_RST;
    init_code  = INIT_CODE_RST;
    init_pd    = INIT_PD_RST;
    byte_pos   = '0;
    wr_mode    = WM_IDLE;
    pend_code  = '0;
    pend_pd    = '0;
    out_code   = INIT_CODE_RST;
    out_pd     = INIT_PD_RST;
    nv_code    = INIT_CODE_RST;
    nv_pd      = INIT_PD_RST;
    busy_left  = '0;
    n_in         = 0;
    n_out        = 0;
    errors       = 0;
    hold_left    = 0;
    stall_cycles = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // fast write at full scale with an extra byte
    add_event(KIND_WRITE, 8'h3F);
    add_event(KIND_WRITE, 8'hFF);
    add_event(KIND_WRITE, 8'hAA);
    add_event(KIND_STOP, 8'h00);
    // unknown command
    add_event(KIND_WRITE, 8'h80);
    add_event(KIND_STOP, 8'hFF);
    // persistent write, then a write while the eeprom is busy
    add_event(KIND_WRITE, 8'h66);
    add_event(KIND_WRITE, 8'hAB);
    add_event(KIND_WRITE, 8'hCF);
    add_event(KIND_STOP, 8'h00);
    add_event(KIND_WRITE, 8'h0F);
    add_event(KIND_STOP, 8'h00);
    // long readback that wraps, then a write after the reads
    repeat (6) add_event(KIND_READ, 8'h00);
    add_event(KIND_WRITE, 8'h01);
    add_event(KIND_STOP, 8'h00);
    // read in the middle of a write
    add_event(KIND_WRITE, 8'h61);
    add_event(KIND_READ, 8'hFF);
    add_event(KIND_STOP, 8'h00);
    add_event(KIND_TICK, 8'h55);
    wait_drained();

    run_phase(16'd0, 16'd0, 16'd0, 260);
    run_phase(16'd3, 16'hFFFF, 16'hFFFF, 260);
    run_phase(16'($urandom_range(1, 20)), 16'($urandom), 16'($urandom), 260);
    run_phase(16'd1, 16'($urandom), 16'($urandom), 260);
    run_phase(16'hFFFF, 16'($urandom), 16'($urandom), 260);

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("i2c_dac_register_model_tb: clean");
    end else begin
      $display("i2c_dac_register_model_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/i2cdac_pkg.sv
rtl/i2cdac_front.sv
rtl/i2cdac_back.sv
rtl/i2cdac_outq.sv
rtl/i2c_dac_register_model.sv
sim/i2c_dac_register_model_tb.sv
